// File: rtl/alc_pkg.sv
// alc_pkg: shared widths, constants and the per-pixel source-over blend
// for the ARGB layer compositor. No dependencies.
`default_nettype none

package alc_pkg;

   localparam int unsigned PixelWidth = 32;
   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned ColorLanes = 3;

   localparam logic [ChanWidth-1:0] ChanMax     = 8'd255;
   localparam logic [ChanWidth-1:0] AlphaOpaque = 8'hFF;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [ChanWidth-1:0]  chan_type;

   // floor(x / 255) for x <= 255*255; exact over that range
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // out = floor((s*a + d*(255-a)) / 255) per color lane; alpha forced opaque
   function automatic pixel_type blend_over(input pixel_type dst, input pixel_type src);
      chan_type    a;
      chan_type    na;
      logic [15:0] sum;
      pixel_type   res;
      a   = src[31:24];
      na  = ChanMax - a;
      res = '0;
      for (int i = 0; i < ColorLanes; i++) begin
         // s*a + d*(255-a) never exceeds 255*255, fits 16 bits
         sum = 16'(src[i*ChanWidth +: ChanWidth] * a)
             + 16'(dst[i*ChanWidth +: ChanWidth] * na);
         res[i*ChanWidth +: ChanWidth] = div255(sum);
      end
      res[31:24] = AlphaOpaque;
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/alc_if.sv
// Stream interfaces of the ARGB layer compositor: layer items in, composites out.
// Depends on alc_pkg.
`default_nettype none

interface alc_req_if;
   logic               valid;
   logic               ready;
   alc_pkg::pixel_type layer_pixel;
   logic               is_base;
   logic               is_final_layer;
   logic               end_of_line;

   modport source (output valid, layer_pixel, is_base, is_final_layer, end_of_line,
                   input ready);
   modport sink   (input valid, layer_pixel, is_base, is_final_layer, end_of_line,
                   output ready);
endinterface

interface alc_rsp_if;
   logic               valid;
   logic               ready;
   alc_pkg::pixel_type composite_pixel;
   logic               line_end;

   modport source (output valid, composite_pixel, line_end, input ready);
   modport sink   (input valid, composite_pixel, line_end, output ready);
endinterface

`default_nettype wire

// File: rtl/argb_layer_compositor.sv
// ARGB8888 layer compositor top level: input register, blend into accumulator,
// result register. Depends on alc_pkg and the alc_req_if / alc_rsp_if interfaces.
//
// Usage:
//   req_chan carries one layer pixel per transfer. is_base loads the pixel
//   into the accumulator as is; any other item blends source-over onto the
//   accumulator (alpha of the blend forced to 0xFF). An item with
//   is_final_layer set makes one rsp_chan transfer holding the accumulator
//   after that item, with line_end copied from its end_of_line. Other items
//   make no transfer. The accumulator keeps its value after a composite leaves.
//   Path: a final item passes through the input register and is then written
//   to the result register, from which it is offered on rsp_chan.
//   Throughput: one layer item per cycle while no final item waits for the
//   result slot. The blend of one layer onto the accumulator (six 8x8 products
//   plus an exact divide by 255) is combinational between input register and
//   accumulator, which is what allows back-to-back layers of the same pixel.
//   Stall: while rsp_chan.ready is low and a composite is waiting, non-final
//   items keep flowing; a final item waits in the input register and then
//   req_chan.ready drops.
//   Reset (synchronous, active high): both registers empty, accumulator zero.
`default_nettype none

module argb_layer_compositor (
   input  wire logic clock,
   input  wire logic reset,
   alc_req_if.sink   req_chan,
   alc_rsp_if.source rsp_chan
);
   import alc_pkg::*;

   // input register
   logic      in_valid_ff, in_valid_in;
   pixel_type in_pixel_ff;
   logic      in_base_ff;
   logic      in_final_ff;
   logic      in_eol_ff;

   // accumulator and result register
   pixel_type acc_ff, acc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff;
   logic      rsp_eol_ff;

   logic      advance;
   logic      req_take;

   // item in the input register moves on; a final one needs the result slot
   assign advance  = in_valid_ff && (!in_final_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // base loads, anything else blends onto what the accumulator holds
   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         acc_in = in_base_ff ? in_pixel_ff : blend_over(acc_ff, in_pixel_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_final_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pixel_ff <= req_chan.layer_pixel;
         in_base_ff  <= req_chan.is_base;
         in_final_ff <= req_chan.is_final_layer;
         in_eol_ff   <= req_chan.end_of_line;
      end
      if (advance && in_final_ff) begin
         rsp_pixel_ff <= acc_in;
         rsp_eol_ff   <= in_eol_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.composite_pixel = rsp_pixel_ff;
   assign rsp_chan.line_end        = rsp_eol_ff;

   // a final item leaving the input register always fills the result slot
   a_final_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |=> rsp_valid_ff)
      else $error("final item did not produce a composite");

   // a blended layer always leaves an opaque accumulator
   a_blend_opaque: assert property (@(posedge clock) disable iff (reset)
      advance && !in_base_ff |=> acc_ff[31:24] == AlphaOpaque)
      else $error("blended accumulator alpha not opaque");

   // a base item loads the accumulator verbatim
   a_base_loads: assert property (@(posedge clock) disable iff (reset)
      advance && in_base_ff |=> acc_ff == $past(in_pixel_ff))
      else $error("base item not loaded into accumulator");

   // accumulator only changes when an item advances
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff))
      else $error("accumulator changed without an item");

   // a held input item is not overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_pixel_ff))
      else $error("stalled input item lost");

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking bench for argb_layer_compositor (source-over layer blend).
// Depends on alc_pkg, alc_req_if / alc_rsp_if and the compositor top level.
`timescale 1ns / 1ps

module tb;
   import alc_pkg::*;

   localparam int unsigned RandomItems = 400;    // stop offering random stacks after this
   localparam int unsigned CycleLimit  = 200000; // watchdog, far above the slowest good run
   localparam int unsigned ReportLimit = 10;     // detailed reports, the rest only counted
   localparam int unsigned MaxGap      = 5;      // longest idle/stall drawn per transfer
   localparam int unsigned HoldCycles  = 80;     // long sink hold-off, fills the pipe
   localparam int unsigned DrainCycles = 8;      // drain margin for stray composites

   typedef struct packed {
      pixel_type pixel;
      logic      line_end;
   } composite_type;

   // Tracks the accumulator and the composites still owed by the block.
   class composite_scoreboard;
      pixel_type     acc_pixel;
      composite_type owed_q[$];
      int unsigned   failures;

      function new();
         acc_pixel = '0;
         failures  = 0;
      endfunction

      // Per color lane: floor((s*a + d*(255-a)) / 255); alpha ends up opaque.
      function pixel_type blend_src_over(input pixel_type dst, input pixel_type src);
         int unsigned alpha;
         int unsigned s;
         int unsigned d;
         pixel_type   res;
         alpha = src[31:24];
         res   = '0;
         for (int lane = 0; lane < 3; lane++) begin
            s = src[lane*8 +: 8];
            d = dst[lane*8 +: 8];
            res[lane*8 +: 8] = chan_type'((s * alpha + d * (int'(ChanMax) - alpha))
                                          / int'(ChanMax));
         end
         res[31:24] = AlphaOpaque;
         return res;
      endfunction

      function void note_layer(input pixel_type px, input logic base, input logic fin,
                               input logic eol);
         composite_type c;
         if (base) begin
            acc_pixel = px;
         end else begin
            acc_pixel = blend_src_over(acc_pixel, px);
         end
         if (fin) begin
            c.pixel    = acc_pixel;
            c.line_end = eol;
            owed_q.push_back(c);
         end
      endfunction

      function void check_composite(input pixel_type px, input logic le);
         composite_type want;
         if (owed_q.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("[%0t] composite with none owed: pixel %h line_end %b",
                        $realtime, px, le);
            end
            return;
         end
         want = owed_q.pop_front();
         if (px !== want.pixel || le !== want.line_end) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("[%0t] composite mismatch: expected pixel %h line_end %b, got %h %b",
                        $realtime, want.pixel, want.line_end, px, le);
            end
         end
      endfunction

      function int unsigned owed();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   alc_req_if req_chan();
   alc_rsp_if rsp_chan();

   argb_layer_compositor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   composite_scoreboard sb = new();

   int unsigned items_sent;     // random-phase layer transfers made so far
   int unsigned cycle_count;
   logic        sender_steady;  // 1: back-to-back layers, no idle cycles
   logic        hold_pending;   // request for one long sink hold-off

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Monitors. Both sample at the rising edge; stimulus moves only at the
   // falling edge, so every sampled value is settled.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         sb.note_layer(req_chan.layer_pixel, req_chan.is_base, req_chan.is_final_layer,
                       req_chan.end_of_line);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_composite(rsp_chan.composite_pixel, rsp_chan.line_end);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Composite sink. Per transfer it draws a stall bounded by MaxGap, sometimes runs
   // a stretch with no stalls at all, and on request holds off for HoldCycles so
   // that a composite parks in the result register, a final layer parks
   // behind it and req_chan.ready drops.
   // ---------------------------------------------------------------------
   initial begin : composite_sink
      int unsigned stall;
      int unsigned steady_left;
      rsp_chan.ready = 1'b0;
      steady_left    = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = HoldCycles;
         end else if (steady_left > 0) begin
            steady_left--;
            stall = 0;
         end else begin
            if ($urandom_range(0, 7) == 0) steady_left = $urandom_range(5, 30);
            stall = $urandom_range(0, MaxGap);
         end
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Layer source. Entered just after a falling edge; leaves just after the
   // falling edge that follows the transfer. valid stays high between
   // back-to-back layers.
   // ---------------------------------------------------------------------
   task automatic send_layer(input pixel_type px, input logic base, input logic fin,
                             input logic eol);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid          = 1'b1;
      req_chan.layer_pixel    = px;
      req_chan.is_base        = base;
      req_chan.is_final_layer = fin;
      req_chan.end_of_line    = eol;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Alpha biased toward the extremes, where the blend degenerates.
   function automatic pixel_type rand_pixel();
      chan_type alpha;
      case ($urandom_range(0, 3))
         0:       alpha = 8'h00;
         1:       alpha = AlphaOpaque;
         default: alpha = chan_type'($urandom_range(0, 255));
      endcase
      return {alpha, 24'($urandom)};
   endfunction

   // Well-formed stack for one screen pixel: base, 0..4 layers, last one final.
   // A lone base is its own final item. eol on inner items must be dropped.
   task automatic send_pixel_stack();
      int unsigned layers;
      logic        eol;
      layers        = $urandom_range(0, 4);
      eol           = 1'($urandom_range(0, 1));
      sender_steady = ($urandom_range(0, 3) == 0);
      send_layer(rand_pixel(), 1'b1, layers == 0, (layers == 0) ? eol : 1'($urandom));
      for (int unsigned k = 1; k <= layers; k++) begin
         send_layer(rand_pixel(), 1'b0, k == layers, (k == layers) ? eol : 1'($urandom));
      end
   endtask

   // Broken sequences: layers with no base, bases with no final, random flags.
   task automatic send_noise();
      int unsigned n;
      n             = $urandom_range(1, 3);
      sender_steady = ($urandom_range(0, 1) == 0);
      repeat (n) send_layer(rand_pixel(), 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      hold_pending            = 1'b0;
      sender_steady           = 1'b0;
      items_sent              = 0;
      req_chan.valid          = 1'b0;
      req_chan.layer_pixel    = '0;
      req_chan.is_base        = 1'b0;
      req_chan.is_final_layer = 1'b0;
      req_chan.end_of_line    = 1'b0;
      reset                   = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // -- directed --
      // layer with no base right after reset: blends onto the zero accumulator
      send_layer(32'h80FF_FFFF, 1'b0, 1'b1, 1'b0);
      // again with no base: blends onto the composite the accumulator kept
      send_layer(32'h4010_2030, 1'b0, 1'b1, 1'b1);
      // base that is also final: emitted as is, alpha not forced
      send_layer(32'h1234_5678, 1'b1, 1'b1, 1'b0);
      send_layer(32'h0000_0000, 1'b1, 1'b1, 1'b1);
      send_layer(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
      // fully transparent source: color kept, alpha forced opaque;
      // eol on the non-final base must not leak
      send_layer(32'h00AB_CDEF, 1'b1, 1'b0, 1'b1);
      send_layer(32'h0000_0000, 1'b0, 1'b1, 1'b0);
      // opaque source replaces the color
      send_layer(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
      send_layer(32'hFF00_0000, 1'b0, 1'b1, 1'b1);
      // second base overrides the first, then near-extreme alphas
      send_layer(32'h1122_3344, 1'b1, 1'b0, 1'b0);
      send_layer(32'h7F80_8080, 1'b1, 1'b0, 1'b0);
      send_layer(32'h01FF_FFFF, 1'b0, 1'b0, 1'b0);
      send_layer(32'hFE00_0000, 1'b0, 1'b0, 1'b1);
      send_layer(32'h7F55_AA55, 1'b0, 1'b1, 1'b1);
      // black base under transparent white, then opaque white
      send_layer(32'h0000_0000, 1'b1, 1'b0, 1'b0);
      send_layer(32'h00FF_FFFF, 1'b0, 1'b0, 1'b0);
      send_layer(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);

      // -- random --
      items_sent = 0;
      while (items_sent < RandomItems) begin
         // halfway through: sink holds off while layers keep coming
         if (items_sent >= RandomItems / 2 && items_sent < RandomItems / 2 + 5) begin
            hold_pending = 1'b1;
         end
         if ($urandom_range(0, 99) < 85) begin
            send_pixel_stack();
         end else begin
            send_noise();
         end
      end
      req_chan.valid = 1'b0;

      // drain: every owed composite, then a DrainCycles margin for strays
      while (sb.owed() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.failures == 0 && sb.owed() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/alc_pkg.sv
rtl/alc_if.sv
rtl/argb_layer_compositor.sv
dv/tb.sv
